[rtl/ppe_pkg.sv]
// Shared types, constants and codes of the packed pattern event decoder.
`default_nettype none

package ppe_pkg;

    localparam int CHANNEL_BITS = 5;
    localparam int QUEUE_DEPTH  = 4;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_CHANNELS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TEMPO_CODE      = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KEY_OFF_CODE    = 2'd2;

    localparam logic [5:0] RST_CHANNELS_IN_USE = 6'd32;
    localparam logic [7:0] RST_TEMPO_CODE      = 8'd163;
    localparam logic [7:0] RST_KEY_OFF_CODE    = 8'd129;

    localparam int FLAG_BIT_EFFECT = 7;
    localparam int FLAG_BIT_NOTE   = 6;
    localparam int FLAG_BIT_VOLUME = 5;

    localparam logic [7:0] FX_TEMPO      = 8'h14;
    localparam logic [7:0] FX_LAST_KNOWN = 8'h0f;
    localparam logic [7:0] NOTE_KEY_OFF  = 8'd128;
    localparam logic [7:0] NOTE_OFFSET   = 8'd12;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_LEN,
        PH_ROWS,
        PH_FLAG,
        PH_FXP,
        PH_FXT,
        PH_INS,
        PH_NOTE,
        PH_VOL
    } t_phase;

    // Raw entry as parsed; byte translation happens in the back end.
    typedef struct packed {
        logic [7:0]              pattern;
        logic [7:0]              row;
        logic [CHANNEL_BITS-1:0] channel;
        logic                    has_effect;
        logic [7:0]              fx_type;
        logic [7:0]              fx_param;
        logic                    has_note;
        logic [7:0]              instrument;
        logic [7:0]              note;
        logic                    has_volume;
        logic [7:0]              vol;
        logic                    done;
    } t_event;

    typedef struct packed {
        logic [7:0]              pattern_number;
        logic [7:0]              row_index;
        logic [CHANNEL_BITS-1:0] channel_index;
        logic                    has_effect;
        logic [7:0]              effect_type;
        logic [7:0]              effect_param;
        logic                    has_note;
        logic [7:0]              instrument;
        logic [7:0]              note_value;
        logic                    has_volume;
        logic [7:0]              volume;
        logic                    pattern_done;
    } t_result;

endpackage

`default_nettype wire

[rtl/ppe_front.sv]
// Front end: byte parser that turns the chunk body into raw entry beats.
`default_nettype none

module ppe_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic [7:0]     i_data_byte,
    input  wire logic           i_chunk_start,
    input  wire logic [5:0]     i_channels_in_use,
    output ppe_pkg::t_event     o_event,
    output logic                o_emit
);
    import ppe_pkg::*;

    t_phase      r_phase;
    t_phase      n_phase;
    logic [1:0]  r_len_cnt;
    logic [7:0]  r_pattern;
    logic [7:0]  r_last_row;
    logic [8:0]  r_row;
    logic [7:0]  r_flag;
    logic [7:0]  r_fx_param;
    logic [7:0]  r_fx_type;
    logic [7:0]  r_instrument;
    logic [7:0]  r_note;

    logic [8:0]  w_row_next;
    logic        w_row_done;
    logic [7:0]  w_flag;
    logic        w_complete;
    logic        w_chan_ok;

    assign w_row_next = r_row + 9'd1;
    assign w_row_done = w_row_next > {1'b0, r_last_row};
    assign w_flag     = (r_phase == PH_FLAG) ? i_data_byte : r_flag;
    assign w_chan_ok  = {1'b0, w_flag[CHANNEL_BITS-1:0]} < i_channels_in_use;

    always_comb begin
        n_phase = r_phase;
        if (i_valid) begin
            if (i_chunk_start) begin
                n_phase = PH_LEN;
            end else begin
                case (r_phase)
                    PH_IDLE: n_phase = PH_IDLE;
                    PH_LEN:  n_phase = (r_len_cnt == 2'd3) ? PH_ROWS : PH_LEN;
                    PH_ROWS: n_phase = PH_FLAG;
                    PH_FLAG: begin
                        if (i_data_byte == 8'd0) begin
                            n_phase = w_row_done ? PH_IDLE : PH_FLAG;
                        end else if (i_data_byte[FLAG_BIT_EFFECT]) begin
                            n_phase = PH_FXP;
                        end else if (i_data_byte[FLAG_BIT_NOTE]) begin
                            n_phase = PH_INS;
                        end else if (i_data_byte[FLAG_BIT_VOLUME]) begin
                            n_phase = PH_VOL;
                        end else begin
                            n_phase = PH_FLAG;
                        end
                    end
                    PH_FXP:  n_phase = PH_FXT;
                    PH_FXT: begin
                        if (r_flag[FLAG_BIT_NOTE]) begin
                            n_phase = PH_INS;
                        end else if (r_flag[FLAG_BIT_VOLUME]) begin
                            n_phase = PH_VOL;
                        end else begin
                            n_phase = PH_FLAG;
                        end
                    end
                    PH_INS:  n_phase = PH_NOTE;
                    PH_NOTE: n_phase = r_flag[FLAG_BIT_VOLUME] ? PH_VOL : PH_FLAG;
                    PH_VOL:  n_phase = PH_FLAG;
                    default: n_phase = PH_IDLE;
                endcase
            end
        end
    end

    always_comb begin
        w_complete         = 1'b0;
        o_emit             = 1'b0;
        o_event.pattern    = r_pattern;
        o_event.row        = r_row[7:0];
        o_event.channel    = w_flag[CHANNEL_BITS-1:0];
        o_event.has_effect = w_flag[FLAG_BIT_EFFECT];
        o_event.fx_type    = (r_phase == PH_FXT) ? i_data_byte : r_fx_type;
        o_event.fx_param   = r_fx_param;
        o_event.has_note   = w_flag[FLAG_BIT_NOTE];
        o_event.instrument = r_instrument;
        o_event.note       = (r_phase == PH_NOTE) ? i_data_byte : r_note;
        o_event.has_volume = (r_phase == PH_VOL);
        o_event.vol        = i_data_byte;
        o_event.done       = 1'b0;
        if (i_valid && !i_chunk_start) begin
            case (r_phase)
                PH_FLAG: begin
                    if (i_data_byte == 8'd0) begin
                        if (w_row_done) begin
                            o_emit             = 1'b1;
                            o_event            = '0;
                            o_event.pattern    = r_pattern;
                            o_event.row        = r_last_row;
                            o_event.done       = 1'b1;
                        end
                    end else begin
                        w_complete = !i_data_byte[FLAG_BIT_EFFECT] &&
                                     !i_data_byte[FLAG_BIT_NOTE] &&
                                     !i_data_byte[FLAG_BIT_VOLUME];
                    end
                end
                PH_FXT:  w_complete = !r_flag[FLAG_BIT_NOTE] && !r_flag[FLAG_BIT_VOLUME];
                PH_NOTE: w_complete = !r_flag[FLAG_BIT_VOLUME];
                PH_VOL:  w_complete = 1'b1;
                default: w_complete = 1'b0;
            endcase
            if (w_complete) begin
                o_emit = w_chan_ok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_len_cnt <= 2'd0;
        end else begin
            r_phase <= n_phase;
            if (i_valid) begin
                if (i_chunk_start) begin
                    r_len_cnt <= 2'd0;
                end else if (r_phase == PH_LEN) begin
                    r_len_cnt <= r_len_cnt + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            if (i_chunk_start) begin
                r_pattern <= i_data_byte;
            end else begin
                case (r_phase)
                    PH_ROWS: begin
                        r_last_row <= i_data_byte;
                        r_row      <= 9'd0;
                    end
                    PH_FLAG: begin
                        if (i_data_byte == 8'd0) begin
                            r_row <= w_row_next;
                        end else begin
                            r_flag <= i_data_byte;
                        end
                    end
                    PH_FXP:  r_fx_param   <= i_data_byte;
                    PH_FXT:  r_fx_type    <= i_data_byte;
                    PH_INS:  r_instrument <= i_data_byte;
                    PH_NOTE: r_note       <= i_data_byte;
                    default: r_note       <= r_note;
                endcase
            end
        end
    end

    a_done_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit && o_event.done) |=> (r_phase == PH_IDLE))
        else $error("Closing beat did not return the parser to idle.");

    a_emit_channel_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit && !o_event.done) |-> ({1'b0, o_event.channel} < i_channels_in_use))
        else $error("Entry beat emitted for a channel that is not in use.");

endmodule

`default_nettype wire

[rtl/ppe_fifo.sv]
// Short queue of raw entry beats between the parser and the result stage.
`default_nettype none

module ppe_fifo #(
    parameter int DEPTH = ppe_pkg::QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  ppe_pkg::t_event     i_data,
    output logic                o_full,
    input  wire logic           i_pop,
    output ppe_pkg::t_event     o_data,
    output logic                o_empty
);
    import ppe_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR  = PW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

    t_event         r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           w_wr;
    logic           w_rd;

    assign o_full  = (r_count == DEPTH_CNT);
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + CW'(1);
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_CNT)
        else $error("Queue occupancy exceeds its depth.");

    a_count_tracks_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !o_full && !i_pop) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("Queue occupancy did not follow a lone push.");

endmodule

`default_nettype wire

[rtl/ppe_back.sv]
// Back end: translates raw entry beats into result fields and holds the output beat.
`default_nettype none

module ppe_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  ppe_pkg::t_event     i_event,
    output logic                o_take,
    input  wire logic [7:0]     i_tempo_code,
    input  wire logic [7:0]     i_key_off_code,
    output ppe_pkg::t_result    o_result,
    output logic                o_empty,
    input  wire logic           i_pop
);
    import ppe_pkg::*;

    t_result  r_result;
    t_result  n_result;
    logic     r_full;
    logic     w_fx_known;

    assign o_take     = i_valid && (!r_full || i_pop);
    assign o_empty    = !r_full;
    assign o_result   = r_result;
    assign w_fx_known = (i_event.fx_type == FX_TEMPO) || (i_event.fx_type <= FX_LAST_KNOWN);

    always_comb begin
        n_result.pattern_number = i_event.pattern;
        n_result.row_index      = i_event.row;
        n_result.channel_index  = i_event.channel;
        n_result.has_effect     = i_event.has_effect;
        n_result.effect_type    = 8'd0;
        n_result.effect_param   = 8'd0;
        if (i_event.has_effect && w_fx_known) begin
            n_result.effect_type  = (i_event.fx_type == FX_TEMPO) ? i_tempo_code
                                                                  : i_event.fx_type;
            n_result.effect_param = i_event.fx_param;
        end
        n_result.has_note   = i_event.has_note;
        n_result.instrument = i_event.has_note ? i_event.instrument : 8'd0;
        n_result.note_value = 8'd0;
        if (i_event.has_note) begin
            if (i_event.note == NOTE_KEY_OFF) begin
                n_result.note_value = i_key_off_code;
            end else if (i_event.note > NOTE_OFFSET) begin
                n_result.note_value = i_event.note - NOTE_OFFSET;
            end
        end
        n_result.has_volume   = i_event.has_volume;
        n_result.volume       = i_event.has_volume ? (8'd1 + {1'b0, i_event.vol[7:1]})
                                                   : 8'd0;
        n_result.pattern_done = i_event.done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (o_take) begin
            r_full <= 1'b1;
        end else if (i_pop) begin
            r_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_result <= n_result;
        end
    end

    a_done_beat_is_bare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_full && r_result.pattern_done) |->
            (!r_result.has_effect && !r_result.has_note && !r_result.has_volume))
        else $error("Closing beat carries entry fields.");

endmodule

`default_nettype wire

[rtl/packed_pattern_event_decoder_core.sv]
// Top level of the packed pattern event decoder: configuration, parser, queue, result stage.
//
// Usage: the chunk body enters one byte per beat on the input queue port
// (i_push / o_full, with i_chunk_start marking the pattern number byte).
// Decoded entries leave on the result queue port (o_empty / i_pop); the
// oldest result is on the o_* fields while o_empty is low.
// A byte is taken every cycle while o_full is low, so the block sustains
// one byte per cycle. The result of an entry passes through the queue and then
// the output register: the parser writes the queue at the edge that accepts its
// last byte, and the entry moves on once the output register is free or being popped.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data with no
// wait states; index 0 is channels in use, 1 the tempo effect code and 2 the
// key-off note code. The user makes writes while the block is idle; it is not enforced.
// Reset empties the queue and the output register and returns the parser to
// idle; the registers return to 32, 163 and 129.
// When the receiver stops popping, the output register holds its beat, the
// queue fills, and o_full rises once it is full; input bytes are then held off.
`default_nettype none

module packed_pattern_event_decoder_core #(
    parameter int QUEUE_DEPTH = ppe_pkg::QUEUE_DEPTH
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [ppe_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  wire logic [7:0]                         i_cfg_data,
    input  wire logic                               i_push,
    output logic                                    o_full,
    input  wire logic [7:0]                         i_data_byte,
    input  wire logic                               i_chunk_start,
    output logic                                    o_empty,
    input  wire logic                               i_pop,
    output logic [7:0]                              o_pattern_number,
    output logic [7:0]                              o_row_index,
    output logic [ppe_pkg::CHANNEL_BITS-1:0]        o_channel_index,
    output logic                                    o_has_effect,
    output logic [7:0]                              o_effect_type,
    output logic [7:0]                              o_effect_param,
    output logic                                    o_has_note,
    output logic [7:0]                              o_instrument,
    output logic [7:0]                              o_note_value,
    output logic                                    o_has_volume,
    output logic [7:0]                              o_volume,
    output logic                                    o_pattern_done
);
    import ppe_pkg::*;

    logic [5:0]  r_channels_in_use;
    logic [7:0]  r_tempo_code;
    logic [7:0]  r_key_off_code;

    logic        w_accept;
    logic        w_emit;
    t_event      w_front_event;
    t_event      w_queue_event;
    logic        w_queue_empty;
    logic        w_take;
    t_result     w_result;

    assign w_accept = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channels_in_use <= RST_CHANNELS_IN_USE;
            r_tempo_code      <= RST_TEMPO_CODE;
            r_key_off_code    <= RST_KEY_OFF_CODE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CHANNELS_IN_USE: r_channels_in_use <= i_cfg_data[5:0];
                CFG_TEMPO_CODE:      r_tempo_code      <= i_cfg_data;
                CFG_KEY_OFF_CODE:    r_key_off_code    <= i_cfg_data;
                default:             r_key_off_code    <= r_key_off_code;
            endcase
        end
    end

    ppe_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (w_accept),
        .i_data_byte       (i_data_byte),
        .i_chunk_start     (i_chunk_start),
        .i_channels_in_use (r_channels_in_use),
        .o_event           (w_front_event),
        .o_emit            (w_emit)
    );

    ppe_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_emit),
        .i_data  (w_front_event),
        .o_full  (o_full),
        .i_pop   (w_take),
        .o_data  (w_queue_event),
        .o_empty (w_queue_empty)
    );

    ppe_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (!w_queue_empty),
        .i_event        (w_queue_event),
        .o_take         (w_take),
        .i_tempo_code   (r_tempo_code),
        .i_key_off_code (r_key_off_code),
        .o_result       (w_result),
        .o_empty        (o_empty),
        .i_pop          (i_pop)
    );

    assign o_pattern_number = w_result.pattern_number;
    assign o_row_index      = w_result.row_index;
    assign o_channel_index  = w_result.channel_index;
    assign o_has_effect     = w_result.has_effect;
    assign o_effect_type    = w_result.effect_type;
    assign o_effect_param   = w_result.effect_param;
    assign o_has_note       = w_result.has_note;
    assign o_instrument     = w_result.instrument;
    assign o_note_value     = w_result.note_value;
    assign o_has_volume     = w_result.has_volume;
    assign o_volume         = w_result.volume;
    assign o_pattern_done   = w_result.pattern_done;

endmodule

`default_nettype wire
